// ----- rtl/core/epms_pkg.sv -----
// shared types and constants for the point mass euler stepper
// no dependencies
package epms_pkg;

	localparam logic [31:0] DEFAULT_MASS = 32'd65536;
	localparam logic [31:0] MASS_RST     = 32'd65536;
	localparam logic [31:0] GRAV_RST     = 32'd642908;
	localparam logic [23:0] FRIC_RST     = 24'd16777;

	localparam logic [1:0] REG_MASS = 2'd0;
	localparam logic [1:0] REG_GRAV = 2'd1;
	localparam logic [1:0] REG_FRIC = 2'd2;

	localparam logic CMD_FORCE = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef struct packed {
		logic               command;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic        [15:0] time_step;
		logic               below_empty;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} out_beat_t;

	// lane start strobe, shared operands and per-lane force
	typedef struct packed {
		logic               start;
		logic        [31:0] mass;
		logic signed [32:0] force_val;
		logic        [23:0] fric;
		logic        [15:0] dt;
	} lane_cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

// ----- rtl/core/epms_lane.sv -----
// one axis lane: friction, bit-serial divide, velocity and position update
// depends on epms_pkg
module epms_lane import epms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_cmd_t          cmd,
	input  logic               zero_vel,
	input  logic signed [31:0] vel_in,
	input  logic signed [31:0] pos_in,
	output logic               done,
	output logic signed [31:0] vel_out,
	output logic signed [31:0] pos_out
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FRIC = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_DV   = 3'd3;
	localparam logic [2:0] ST_DP   = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]         state_q;
	logic [5:0]         cnt_q;
	logic signed [31:0] v_q, p_q;
	logic signed [32:0] f_q;
	logic signed [31:0] fsat_q;
	logic [47:0]        quo_q;
	logic [32:0]        rem_q;
	logic               neg_q;
	logic signed [31:0] acc_q;

	logic signed [56:0] fr_prod;
	logic [47:0]        dividend;
	logic [32:0]        rem_sh;
	logic signed [48:0] qs;
	logic signed [48:0] dv_prod;
	logic signed [48:0] dp_prod;

	assign fr_prod  = v_q * $signed({1'b0, cmd.fric});
	assign dividend = {(fsat_q[31] ? 32'(-fsat_q) : 32'(fsat_q)), 16'd0};
	assign rem_sh   = {rem_q[31:0], quo_q[47]};
	assign qs       = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign dv_prod  = acc_q * $signed({1'b0, cmd.dt});
	assign dp_prod  = v_q * $signed({1'b0, cmd.dt});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (cmd.start) state_q <= ST_FRIC;
				ST_FRIC: state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == 6'd0) begin
						cnt_q <= 6'd48;
					end else if (cnt_q == 6'd1) begin
						state_q <= ST_DV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_DV:   state_q <= ST_DP;
				ST_DP:   state_q <= ST_DONE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				v_q <= zero_vel ? 32'sd0 : vel_in;
				p_q <= pos_in;
				f_q <= cmd.force_val;
			end
			ST_FRIC: begin
				// friction floored by arithmetic shift
				fsat_q <= sat32(66'(f_q) - 66'(fr_prod >>> 24));
			end
			ST_DIV: begin
				if (cnt_q == 6'd0) begin
					quo_q <= dividend;
					rem_q <= '0;
					neg_q <= fsat_q[31];
				end else begin
					// one restoring step per cycle
					if (rem_sh >= {1'b0, cmd.mass}) begin
						rem_q <= rem_sh - {1'b0, cmd.mass};
						quo_q <= {quo_q[46:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[46:0], 1'b0};
					end
				end
			end
			ST_DV: begin
				acc_q <= sat32(66'(qs));
			end
			ST_DP: begin
				v_q <= sat32(66'(v_q) + 66'(dv_prod >>> 16));
			end
			ST_DONE: begin
				p_q <= sat32(66'(p_q) + 66'(dp_prod >>> 16));
			end
			default: ;
		endcase
	end

	// divide finishes on last step: quotient shifted 48 times total
	assign done    = (state_q == ST_DONE);
	assign vel_out = v_q;
	assign pos_out = sat32(66'(p_q) + 66'(dp_prod >>> 16));

endmodule

// ----- rtl/core/euler_point_mass_step.sv -----
// top level: config registers, force sums, three axis lanes and result merge
// depends on epms_pkg and epms_lane
//
// channel | direction | payload    | handshake
// in      | input     | in_beat_t  | in_valid / in_stall
// out     | output    | out_beat_t | out_valid / out_stall
// cfg     | input     | 32b apb    | psel penable pwrite pready
//
// a force beat is added to the force sums when taken; a step beat raises out_valid
// after it is taken, once friction, a divide (load plus 48 restoring steps),
// then velocity, position and merge are done; the three axes run in parallel.
// reset clears state, positions, velocities, force sums; loads config defaults.
// the result register holds under out_stall; a new beat waits until it is taken.
module euler_point_mass_step import epms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] mass_q, grav_q;
	logic [23:0] fric_q;
	logic signed [31:0] fsum_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] pos_q [3];
	logic        busy_q;
	logic        ovalid_q;
	out_beat_t   odata_q;

	logic [31:0] m_eff;
	logic [47:0] w_full;
	logic [32:0] w_sat;
	logic signed [32:0] fy_adj;
	logic        accept, start;
	logic [15:0] dt_q;
	logic [1:0]  reg_idx;
	lane_cmd_t   lcmd [3];
	logic [2:0]  ldone;
	logic signed [31:0] lvel [3], lpos [3];

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	always_comb begin
		case (reg_idx)
			REG_MASS: prdata = mass_q;
			REG_GRAV: prdata = grav_q;
			REG_FRIC: prdata = {8'd0, fric_q};
			default:  prdata = '0;
		endcase
	end

	assign m_eff  = (mass_q != 0) ? mass_q : ((DEFAULT_MASS != 0) ? DEFAULT_MASS : 32'd1);
	assign w_full = 48'((64'(grav_q) * 64'(m_eff)) >> 16);
	assign w_sat  = (w_full > 48'h1_0000_0000) ? 33'h1_0000_0000 : w_full[32:0];

	assign in_stall = busy_q || ovalid_q;
	assign accept   = in_valid && !in_stall;
	assign start    = accept && in_data.command == CMD_STEP;

	// weight folded into y force at start when below_empty is set
	assign fy_adj = in_data.below_empty
		? 33'(sat32(66'(fsum_q[1]) - 66'($signed({1'b0, w_sat})))) : 33'(fsum_q[1]);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lcmd[i].start = start;
			lcmd[i].mass  = m_eff;
			lcmd[i].fric  = fric_q;
			lcmd[i].dt    = dt_q;
			lcmd[i].force_val = (i == 1) ? fy_adj : 33'(fsum_q[i]);
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		epms_lane u_lane (
			.clk(clk), .arst_n(arst_n), .cmd(lcmd[g]),
			.zero_vel(!in_data.below_empty),
			.vel_in(vel_q[g]), .pos_in(pos_q[g]),
			.done(ldone[g]), .vel_out(lvel[g]), .pos_out(lpos[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q   <= MASS_RST;
			grav_q   <= GRAV_RST;
			fric_q   <= FRIC_RST;
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				fsum_q[i] <= '0;
				vel_q[i]  <= '0;
				pos_q[i]  <= '0;
			end
		end else begin
			if (psel && penable && pwrite) begin
				case (reg_idx)
					REG_MASS: mass_q <= pwdata;
					REG_GRAV: grav_q <= pwdata;
					REG_FRIC: fric_q <= pwdata[23:0];
					default: ;
				endcase
			end
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			if (accept && in_data.command == CMD_FORCE) begin
				fsum_q[0] <= sat32(66'(fsum_q[0]) + 66'(in_data.force_x));
				fsum_q[1] <= sat32(66'(fsum_q[1]) + 66'(in_data.force_y));
				fsum_q[2] <= sat32(66'(fsum_q[2]) + 66'(in_data.force_z));
			end
			if (start) busy_q <= 1'b1;
			// merge: lanes run in lock step, so all finish together
			if (busy_q && ldone[0]) begin
				busy_q   <= 1'b0;
				ovalid_q <= 1'b1;
				for (int i = 0; i < 3; i++) begin
					fsum_q[i] <= '0;
					vel_q[i]  <= lvel[i];
					pos_q[i]  <= lpos[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		// time step held for the whole step, the input may move on
		if (start) dt_q <= in_data.time_step;
		if (busy_q && ldone[0]) begin
			odata_q <= '{pos_x: lpos[0], pos_y: lpos[1], pos_z: lpos[2],
			             vel_x: lvel[0], vel_y: lvel[1], vel_z: lvel[2]};
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

endmodule

// ----- rtl/core/epms_checker.sv -----
// port-level checks for euler_point_mass_step, bound to the top level
// depends on epms_pkg
module epms_checker import epms_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_beat_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_beat_t out_data,
	input logic      pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat dropped under stall");

	a_stall_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	a_force_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.command == CMD_FORCE && !out_valid |=> !out_valid)
		else $error("force beat produced a result");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind euler_point_mass_step epms_checker u_epms_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
	.out_data(out_data), .pready(pready)
);

// ----- dv/tb.sv -----
// testbench for euler_point_mass_step: random and directed force/step beats,
// config phases over apb, self-checking against an in-bench euler predictor
// depends on epms_pkg and the rtl of euler_point_mass_step
`timescale 1ns / 100ps

module tb;
	import epms_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int N_PHASES    = 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_beat_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_beat_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	euler_point_mass_step uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [31:0]        cur_mass;
	logic [31:0]        cur_grav;
	logic [23:0]        cur_fric;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] fsum_q [3];

	in_beat_t  pending_beats [$];
	out_beat_t expected_states [$];
	int        sender_idle_pct;
	int        receiver_stall_pct;
	int        n_errors = 0;
	int        n_forces = 0;
	int        n_steps = 0;
	int        quiet_cycles = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic void integrate_beat(input in_beat_t b, output bit has_state,
			output out_beat_t st);
		longint m;
		longint w;
		longint a;
		longint dt;
		longint unsigned wu;
		has_state = 0;
		st = '0;
		if (b.command == CMD_FORCE) begin
			fsum_q[0] = clamp32(longint'(fsum_q[0]) + longint'(b.force_x));
			fsum_q[1] = clamp32(longint'(fsum_q[1]) + longint'(b.force_y));
			fsum_q[2] = clamp32(longint'(fsum_q[2]) + longint'(b.force_z));
			return;
		end
		m = (cur_mass != 0) ? longint'({32'd0, cur_mass}) : longint'({32'd0, DEFAULT_MASS});
		if (m == 0) m = 1;
		dt = longint'({48'd0, b.time_step});
		if (b.below_empty) begin
			wu = (longint'({32'd0, cur_grav}) * m) >> 16;
			if (wu > 64'h1_0000_0000) wu = 64'h1_0000_0000;
			w = wu;
			fsum_q[1] = clamp32(longint'(fsum_q[1]) - w);
		end else begin
			for (int i = 0; i < 3; i++) vel_q[i] = '0;
		end
		for (int i = 0; i < 3; i++)
			fsum_q[i] = clamp32(longint'(fsum_q[i])
				- ((longint'(vel_q[i]) * longint'({40'd0, cur_fric})) >>> 24));
		for (int i = 0; i < 3; i++) begin
			a = clamp32((longint'(fsum_q[i]) * 65536) / m);
			fsum_q[i] = '0;
			vel_q[i] = clamp32(longint'(vel_q[i]) + ((a * dt) >>> 16));
			pos_q[i] = clamp32(longint'(pos_q[i]) + ((longint'(vel_q[i]) * dt) >>> 16));
		end
		st.pos_x = pos_q[0];
		st.pos_y = pos_q[1];
		st.pos_z = pos_q[2];
		st.vel_x = vel_q[0];
		st.vel_y = vel_q[1];
		st.vel_z = vel_q[2];
		has_state = 1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		n_errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit        has;
		out_beat_t st;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				integrate_beat(in_data, has, st);
				if (has) begin
					expected_states.push_back(st);
					n_steps++;
				end else begin
					n_forces++;
				end
			end
			if (!in_valid || !in_stall) begin
				if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= pending_beats.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		out_beat_t w;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_states.size() == 0) begin
					$display("unexpected result beat");
					n_errors++;
				end else begin
					w = expected_states.pop_front();
					if (out_data.pos_x !== w.pos_x) report_mismatch("pos_x", out_data.pos_x, w.pos_x);
					if (out_data.pos_y !== w.pos_y) report_mismatch("pos_y", out_data.pos_y, w.pos_y);
					if (out_data.pos_z !== w.pos_z) report_mismatch("pos_z", out_data.pos_z, w.pos_z);
					if (out_data.vel_x !== w.vel_x) report_mismatch("vel_x", out_data.vel_x, w.vel_x);
					if (out_data.vel_y !== w.vel_y) report_mismatch("vel_y", out_data.vel_y, w.vel_y);
					if (out_data.vel_z !== w.vel_z) report_mismatch("vel_z", out_data.vel_z, w.vel_z);
				end
			end
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// watchdog on beats moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MASS: cur_mass = val;
			REG_GRAV: cur_grav = val;
			REG_FRIC: cur_fric = val[23:0];
			default: ;
		endcase
	endtask

	function automatic logic signed [31:0] rand_force();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(2000000)) - 1000000;
			default: return $signed($urandom_range(200000)) - 100000;
		endcase
	endfunction

	function automatic in_beat_t make_beat(input logic cmd);
		in_beat_t b;
		b.command     = cmd;
		b.force_x     = rand_force();
		b.force_y     = rand_force();
		b.force_z     = rand_force();
		b.time_step   = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
			: 16'($urandom_range(3000));
		b.below_empty = ($urandom_range(3) != 0);
		return b;
	endfunction

	task automatic push(input logic cmd, input logic [31:0] fx, input logic [31:0] fy,
			input logic [31:0] fz, input logic [15:0] dt, input logic be);
		pending_beats.push_back({cmd, fx, fy, fz, dt, be});
	endtask

	task automatic drain();
		wait (pending_beats.size() == 0 && !in_valid && expected_states.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_mass = MASS_RST;
		cur_grav = GRAV_RST;
		cur_fric = FRIC_RST;
		for (int i = 0; i < 3; i++) begin
			pos_q[i] = '0;
			vel_q[i] = '0;
			fsum_q[i] = '0;
		end
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: saturating force sums, extreme time steps, both contact cases
		push(CMD_FORCE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'hffff, 1'b1);
		push(CMD_FORCE, 32'h7fffffff, 32'h80000000, 32'h00000001, 16'h0000, 1'b0);
		push(CMD_STEP, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff, 1'b1);
		push(CMD_STEP, 32'h0, 32'h0, 32'h0, 16'h0000, 1'b1);
		push(CMD_FORCE, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'h0, 1'b0);
		push(CMD_STEP, 32'h0, 32'h0, 32'h0, 16'hffff, 1'b1);
		push(CMD_STEP, 32'h0, 32'h0, 32'h0, 16'hffff, 1'b0);
		push(CMD_FORCE, 32'h00010000, 32'hffff0000, 32'h0, 16'h0, 1'b0);
		push(CMD_STEP, 32'h0, 32'h0, 32'h0, 16'h8000, 1'b0);
		for (int i = 0; i < 6; i++) push(CMD_STEP, 32'h0, 32'h0, 32'h0, 16'hffff, 1'b1);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin apb_write(REG_MASS, 32'd0); apb_write(REG_GRAV, 32'd0);
					apb_write(REG_FRIC, 32'd0); end
				1: begin apb_write(REG_MASS, 32'd1); apb_write(REG_GRAV, 32'hffffffff);
					apb_write(REG_FRIC, 32'hffffff); end
				2: begin apb_write(REG_MASS, 32'hffffffff); apb_write(REG_GRAV, GRAV_RST);
					apb_write(REG_FRIC, FRIC_RST); end
				3: begin apb_write(REG_MASS, MASS_RST); apb_write(REG_GRAV, GRAV_RST);
					apb_write(REG_FRIC, FRIC_RST); end
				default: begin
					apb_write(REG_MASS, ($urandom_range(3) == 0) ? $urandom
						: $urandom_range(400000));
					apb_write(REG_GRAV, ($urandom_range(3) == 0) ? $urandom
						: $urandom_range(1000000));
					apb_write(REG_FRIC, $urandom_range(24'hffffff));
				end
			endcase
			case (ph % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
				default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
			endcase
			for (int k = 0; k < 185; k++)
				pending_beats.push_back(make_beat($urandom_range(1) ? CMD_STEP : CMD_FORCE));
			drain();
		end

		$display("covered %0d force beats and %0d step beats over %0d config phases",
			n_forces, n_steps, N_PHASES);
		$display("config extremes: zero, one and full mass, zero and full gravity and friction");
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
